@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ddpid_pkg.sv @@
// ----------------------------------------------------------------------------
// Differential drive dual PID package
// Shared constants, register indexes and pipeline control types.
// ----------------------------------------------------------------------------
package ddpid_pkg;

  localparam int COUNT_BITS_DEF     = 24;
  localparam int SUM_BITS_DEF       = 40;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  localparam int GAIN_INT_BITS = 8;
  localparam int DRIVE_BITS    = 8;
  localparam int DRIVE_MAX     = 127;
  localparam int CFG_IDX_BITS  = 3;

  localparam int TARGET_DISTANCE_RESET = 500;
  localparam int TARGET_TURN_RESET     = 350;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TARGET_DISTANCE = 3'd0,
    REG_TARGET_TURN     = 3'd1,
    REG_LAT_GAIN_P      = 3'd2,
    REG_LAT_GAIN_I      = 3'd3,
    REG_LAT_GAIN_D      = 3'd4,
    REG_TURN_GAIN_P     = 3'd5,
    REG_TURN_GAIN_I     = 3'd6,
    REG_TURN_GAIN_D     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic load1;
    logic load2;
    logic load3;
  } stage_ctl_t;

endpackage

@@ rtl/ddpid_if.sv @@
// ----------------------------------------------------------------------------
// Differential drive dual PID channels
// Encoder count channel and drive command channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ddpid_in_if #(
  parameter int COUNT_BITS = ddpid_pkg::COUNT_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COUNT_BITS-1:0] left_count;
  logic signed [COUNT_BITS-1:0] right_count;

  modport source (output valid, output left_count, output right_count, input ready);
  modport sink (input valid, input left_count, input right_count, output ready);
endinterface

interface ddpid_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ddpid_pkg::DRIVE_BITS-1:0] left_drive;
  logic signed [ddpid_pkg::DRIVE_BITS-1:0] right_drive;

  modport source (output valid, output left_drive, output right_drive, input ready);
  modport sink (input valid, input left_drive, input right_drive, output ready);
endinterface

@@ rtl/differential_drive_dual_pid_unit.sv @@
// ----------------------------------------------------------------------------
// Differential drive dual PID unit
// Lateral and turn PID loops on wheel encoder counts, mixed into saturated
// left and right drive commands.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// counts    in         left_count, right_count (encoder positions)
// drives    out        left_drive, right_drive (commands, -127..127)
// wr_*      in         register write: enable, index, data
//
// One word is accepted per cycle while counts.ready is high; a result passes
// through the error stage, gain products, PID sums and output mix registers.
// Every stage advances on its own when the next one is free, so a stalled
// output fills the bubbles behind it before counts.ready drops.
// Reset is synchronous and restores registers and loop state at once.
// ----------------------------------------------------------------------------
module differential_drive_dual_pid_unit #(
  parameter int COUNT_BITS     = ddpid_pkg::COUNT_BITS_DEF,
  parameter int SUM_BITS       = ddpid_pkg::SUM_BITS_DEF,
  parameter int GAIN_FRAC_BITS = ddpid_pkg::GAIN_FRAC_BITS_DEF,
  localparam int GB     = ddpid_pkg::GAIN_INT_BITS + GAIN_FRAC_BITS,
  localparam int DATA_W = (COUNT_BITS > GB) ? COUNT_BITS : GB
) (
  input  logic                                clk,
  input  logic                                rst,
  ddpid_in_if.sink                            counts,
  ddpid_out_if.source                         drives,
  input  logic                                wr_en,
  input  logic [ddpid_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  logic [DATA_W-1:0]                   wr_data
);

  localparam int DW    = COUNT_BITS + 3;
  localparam int VW    = (SUM_BITS > DW) ? SUM_BITS : DW;
  localparam int ACC_W = VW + GB + 3;
  localparam int PV_W  = ACC_W - GAIN_FRAC_BITS;
  localparam int MIX_W = PV_W + 2;
  localparam int DB    = ddpid_pkg::DRIVE_BITS;

  localparam logic [GB-1:0] TURN_KP_RESET = GB'((2 * (2 ** GAIN_FRAC_BITS)) / 5);
  localparam logic signed [MIX_W-1:0] SAT_HI = MIX_W'(ddpid_pkg::DRIVE_MAX);
  localparam logic signed [MIX_W-1:0] SAT_LO = -SAT_HI;

  logic signed [COUNT_BITS-1:0] target_distance;
  logic signed [COUNT_BITS-1:0] target_turn;
  logic        [GB-1:0]         lat_gain_p;
  logic        [GB-1:0]         lat_gain_i;
  logic        [GB-1:0]         lat_gain_d;
  logic        [GB-1:0]         turn_gain_p;
  logic        [GB-1:0]         turn_gain_i;
  logic        [GB-1:0]         turn_gain_d;

  logic v1, v2, v3, vo;
  logic rdy1, rdy2, rdy3, rdyo;
  ddpid_pkg::stage_ctl_t ctl;
  logic load_out;

  logic signed [COUNT_BITS:0]   pair_sum;
  logic signed [COUNT_BITS:0]   pair_sum_adj;
  logic signed [COUNT_BITS-1:0] avg;
  logic signed [COUNT_BITS:0]   lat_meas;
  logic signed [COUNT_BITS:0]   turn_meas;

  logic signed [PV_W-1:0] lat_floor;
  logic signed [PV_W-1:0] turn_floor;
  logic                   lat_round;
  logic                   turn_round;
  logic signed [MIX_W-1:0] left_mix;
  logic signed [MIX_W-1:0] right_mix;
  logic signed [DB-1:0]    left_drive;
  logic signed [DB-1:0]    right_drive;

  function automatic logic signed [DB-1:0] sat_drive(input logic signed [MIX_W-1:0] m);
    logic signed [DB-1:0] r;
    if (m > SAT_HI) begin
      r = DB'(SAT_HI);
    end else if (m < SAT_LO) begin
      r = DB'(SAT_LO);
    end else begin
      r = m[DB-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      target_distance <= COUNT_BITS'(ddpid_pkg::TARGET_DISTANCE_RESET);
      target_turn     <= COUNT_BITS'(ddpid_pkg::TARGET_TURN_RESET);
      lat_gain_p      <= '0;
      lat_gain_i      <= '0;
      lat_gain_d      <= '0;
      turn_gain_p     <= TURN_KP_RESET;
      turn_gain_i     <= '0;
      turn_gain_d     <= '0;
    end else if (wr_en) begin
      case (ddpid_pkg::cfg_reg_t'(wr_index))
        ddpid_pkg::REG_TARGET_DISTANCE: target_distance <= wr_data[COUNT_BITS-1:0];
        ddpid_pkg::REG_TARGET_TURN:     target_turn     <= wr_data[COUNT_BITS-1:0];
        ddpid_pkg::REG_LAT_GAIN_P:      lat_gain_p      <= wr_data[GB-1:0];
        ddpid_pkg::REG_LAT_GAIN_I:      lat_gain_i      <= wr_data[GB-1:0];
        ddpid_pkg::REG_LAT_GAIN_D:      lat_gain_d      <= wr_data[GB-1:0];
        ddpid_pkg::REG_TURN_GAIN_P:     turn_gain_p     <= wr_data[GB-1:0];
        ddpid_pkg::REG_TURN_GAIN_I:     turn_gain_i     <= wr_data[GB-1:0];
        ddpid_pkg::REG_TURN_GAIN_D:     turn_gain_d     <= wr_data[GB-1:0];
        default: ;
      endcase
    end
  end

  assign rdyo = !vo || drives.ready;
  assign rdy3 = !v3 || rdyo;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign counts.ready = rdy1;

  assign ctl.load1 = counts.valid && rdy1;
  assign ctl.load2 = v1 && rdy2;
  assign ctl.load3 = v2 && rdy3;
  assign load_out  = v3 && rdyo;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      v1 <= ctl.load1 || (v1 && !rdy2);
      v2 <= ctl.load2 || (v2 && !rdy3);
      v3 <= ctl.load3 || (v3 && !rdyo);
      vo <= load_out || (vo && !drives.ready);
    end
  end

  // The average rounds toward zero: add one to a negative sum before halving.
  always_comb begin
    pair_sum     = (COUNT_BITS+1)'(counts.left_count) + (COUNT_BITS+1)'(counts.right_count);
    pair_sum_adj = pair_sum + {{COUNT_BITS{1'b0}}, pair_sum[COUNT_BITS]};
    avg          = pair_sum_adj[COUNT_BITS:1];
    lat_meas     = (COUNT_BITS+1)'(avg);
    turn_meas    = (COUNT_BITS+1)'(counts.left_count) - (COUNT_BITS+1)'(counts.right_count);
  end

  ddpid_loop #(
    .COUNT_BITS     (COUNT_BITS),
    .SUM_BITS       (SUM_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lat (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .target    (target_distance),
    .measure   (lat_meas),
    .gain_p    (lat_gain_p),
    .gain_i    (lat_gain_i),
    .gain_d    (lat_gain_d),
    .pid_floor (lat_floor),
    .pid_round (lat_round)
  );

  ddpid_loop #(
    .COUNT_BITS     (COUNT_BITS),
    .SUM_BITS       (SUM_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_turn (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .target    (target_turn),
    .measure   (turn_meas),
    .gain_p    (turn_gain_p),
    .gain_i    (turn_gain_i),
    .gain_d    (turn_gain_d),
    .pid_floor (turn_floor),
    .pid_round (turn_round)
  );

  always_comb begin
    left_mix  = MIX_W'(lat_floor) + MIX_W'(turn_floor)
              + MIX_W'($signed({1'b0, lat_round})) + MIX_W'($signed({1'b0, turn_round}));
    right_mix = MIX_W'(lat_floor) - MIX_W'(turn_floor)
              + MIX_W'($signed({1'b0, lat_round})) - MIX_W'($signed({1'b0, turn_round}));
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      left_drive  <= sat_drive(left_mix);
      right_drive <= sat_drive(right_mix);
    end
  end

  assign drives.valid       = vo;
  assign drives.left_drive  = left_drive;
  assign drives.right_drive = right_drive;

endmodule

@@ rtl/ddpid_loop.sv @@
// ----------------------------------------------------------------------------
// Differential drive dual PID loop
// One PID loop: error and saturating integral, gain products, and the
// fixed point sum split into its floor and a round-toward-zero carry.
// ----------------------------------------------------------------------------
module ddpid_loop #(
  parameter int  COUNT_BITS     = ddpid_pkg::COUNT_BITS_DEF,
  parameter int  SUM_BITS       = ddpid_pkg::SUM_BITS_DEF,
  parameter int  GAIN_FRAC_BITS = ddpid_pkg::GAIN_FRAC_BITS_DEF,
  localparam int GB    = ddpid_pkg::GAIN_INT_BITS + GAIN_FRAC_BITS,
  localparam int EW    = COUNT_BITS + 2,
  localparam int DW    = COUNT_BITS + 3,
  localparam int VW    = (SUM_BITS > DW) ? SUM_BITS : DW,
  localparam int ACC_W = VW + GB + 3,
  localparam int PV_W  = ACC_W - GAIN_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ddpid_pkg::stage_ctl_t        ctl,
  input  logic signed [COUNT_BITS-1:0] target,
  input  logic signed [COUNT_BITS:0]   measure,
  input  logic        [GB-1:0]         gain_p,
  input  logic        [GB-1:0]         gain_i,
  input  logic        [GB-1:0]         gain_d,
  output logic signed [PV_W-1:0]       pid_floor,
  output logic                         pid_round
);

  localparam int LO_W = SUM_BITS / 2;
  localparam int HI_W = SUM_BITS - LO_W;
  localparam int PE_W = EW + GB + 1;
  localparam int PD_W = DW + GB + 1;
  localparam int PL_W = LO_W + GB;
  localparam int PH_W = HI_W + GB + 1;

  localparam logic signed [SUM_BITS-1:0] SUM_HI = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_LO = {1'b1, {(SUM_BITS-1){1'b0}}};

  logic signed [EW-1:0]       err;
  logic signed [EW-1:0]       err_next;
  logic signed [SUM_BITS-1:0] err_sum;
  logic signed [SUM_BITS-1:0] err_sum_next;
  logic signed [VW:0]         sum_wide;
  logic signed [DW-1:0]       deriv;
  logic signed [DW-1:0]       deriv_next;

  logic signed [PE_W-1:0]     prod_p;
  logic signed [PD_W-1:0]     prod_d;
  logic        [PL_W-1:0]     prod_i_lo;
  logic signed [PH_W-1:0]     prod_i_hi;
  logic signed [ACC_W-1:0]    acc;

  always_comb begin
    err_next   = EW'(target) - EW'(measure);
    sum_wide   = (VW+1)'(err_sum) + (VW+1)'(err_next);
    deriv_next = DW'(err_next) - DW'(err);
    if (sum_wide > (VW+1)'(SUM_HI)) begin
      err_sum_next = SUM_HI;
    end else if (sum_wide < (VW+1)'(SUM_LO)) begin
      err_sum_next = SUM_LO;
    end else begin
      err_sum_next = sum_wide[SUM_BITS-1:0];
    end
  end

  // The loop state doubles as the first stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      err     <= '0;
      err_sum <= '0;
    end else if (ctl.load1) begin
      err     <= err_next;
      err_sum <= err_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      deriv <= deriv_next;
    end
    if (ctl.load2) begin
      prod_p    <= $signed(err) * $signed({1'b0, gain_p});
      prod_d    <= $signed(deriv) * $signed({1'b0, gain_d});
      prod_i_lo <= err_sum[LO_W-1:0] * gain_i;
      prod_i_hi <= $signed(err_sum[SUM_BITS-1:LO_W]) * $signed({1'b0, gain_i});
    end
    if (ctl.load3) begin
      pid_floor <= acc[ACC_W-1:GAIN_FRAC_BITS];
      pid_round <= acc[ACC_W-1] & (|acc[GAIN_FRAC_BITS-1:0]);
    end
  end

  assign acc = ACC_W'(prod_p) + ACC_W'(prod_d) + ACC_W'($signed({1'b0, prod_i_lo}))
             + (ACC_W'(prod_i_hi) <<< LO_W);

endmodule

@@ rtl/ddpid_checker.sv @@
// ----------------------------------------------------------------------------
// Differential drive dual PID checker
// Port level checks on the drive unit, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddpid_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [ddpid_pkg::DRIVE_BITS-1:0] left_drive,
  input logic signed [ddpid_pkg::DRIVE_BITS-1:0] right_drive
);

  localparam logic signed [ddpid_pkg::DRIVE_BITS-1:0] DRIVE_NEG_FULL =
    {1'b1, {(ddpid_pkg::DRIVE_BITS-1){1'b0}}};

  `ASSERT_CLK(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")
  `ASSERT_CLK_RST(a_in_stall_only_when_full, clk, rst, !in_ready |-> (out_valid && !out_ready), "input stalled with room in the pipeline")
  `ASSERT_CLK_RST(a_drive_range, clk, rst, out_valid |-> (left_drive != DRIVE_NEG_FULL && right_drive != DRIVE_NEG_FULL), "drive outside saturation range")
  `ASSERT_CLK_RST(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(left_drive) && $stable(right_drive)), "stalled drive word changed")

endmodule

bind differential_drive_dual_pid_unit ddpid_checker u_ddpid_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (counts.valid),
  .in_ready    (counts.ready),
  .out_valid   (drives.valid),
  .out_ready   (drives.ready),
  .left_drive  (drives.left_drive),
  .right_drive (drives.right_drive)
);

@@ tb/tb_differential_drive_dual_pid_unit.sv @@
// ----------------------------------------------------------------------------
// Differential drive dual PID unit testbench
// Streams encoder count words through the unit under random source gaps and
// sink stalls. A scoreboard predicts each drive word from its own copy of the
// registers and loop state. The run covers directed extremes, random phases
// with fresh register settings, and a long sink hold.
// ----------------------------------------------------------------------------
module tb_differential_drive_dual_pid_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_W = ddpid_pkg::COUNT_BITS_DEF;
  localparam int REG_W = ddpid_pkg::GAIN_INT_BITS + ddpid_pkg::GAIN_FRAC_BITS_DEF;
  localparam int DRV_W = ddpid_pkg::DRIVE_BITS;
  localparam int LAT_LOOP = 0;
  localparam int TURN_LOOP = 1;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_WORDS = 220;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 24'sh7FFFFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 24'sh800000;
  localparam logic [REG_W-1:0] GAIN_ONE = 24'd1 << ddpid_pkg::GAIN_FRAC_BITS_DEF;
  localparam logic [REG_W-1:0] TURN_GAIN_P_RESET = 24'd26214;
  localparam longint SUM_MAX = (longint'(1) << (ddpid_pkg::SUM_BITS_DEF - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam logic signed [79:0] FRAC_SCALE = 80'sd1 << ddpid_pkg::GAIN_FRAC_BITS_DEF;

  typedef struct packed {
    logic signed [DRV_W-1:0] left;
    logic signed [DRV_W-1:0] right;
  } drive_word_t;

  class drive_scoreboard;
    logic [REG_W-1:0] regs [0:7];
    longint last_err [0:1];
    longint integral [0:1];
    drive_word_t expected_drives [$];
    int unsigned mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[ddpid_pkg::REG_TARGET_DISTANCE] = ddpid_pkg::TARGET_DISTANCE_RESET;
      regs[ddpid_pkg::REG_TARGET_TURN] = ddpid_pkg::TARGET_TURN_RESET;
      regs[ddpid_pkg::REG_TURN_GAIN_P] = TURN_GAIN_P_RESET;
      foreach (last_err[i]) last_err[i] = 0;
      foreach (integral[i]) integral[i] = 0;
      mismatches = 0;
    endfunction

    function void set_reg(ddpid_pkg::cfg_reg_t idx, logic [REG_W-1:0] data);
      regs[idx] = data;
    endfunction

    function logic signed [79:0] loop_step(int lp, longint target, longint measure,
                                           int p_reg);
      longint err;
      longint deriv;
      longint s;
      logic signed [79:0] e_w, s_w, d_w, kp, ki, kd, acc;
      err = target - measure;
      s = integral[lp] + err;
      if (s > SUM_MAX) begin
        s = SUM_MAX;
      end else if (s < SUM_MIN) begin
        s = SUM_MIN;
      end
      integral[lp] = s;
      deriv = err - last_err[lp];
      last_err[lp] = err;
      e_w = err;
      s_w = s;
      d_w = deriv;
      kp = {56'd0, regs[p_reg]};
      ki = {56'd0, regs[p_reg + 1]};
      kd = {56'd0, regs[p_reg + 2]};
      acc = e_w * kp + s_w * ki + d_w * kd;
      return acc / FRAC_SCALE;
    endfunction

    function logic signed [DRV_W-1:0] clamp_drive(logic signed [79:0] v);
      if (v > ddpid_pkg::DRIVE_MAX) return ddpid_pkg::DRIVE_MAX;
      if (v < -ddpid_pkg::DRIVE_MAX) return -ddpid_pkg::DRIVE_MAX;
      return v[DRV_W-1:0];
    endfunction

    function void predict_drives(logic signed [COUNT_W-1:0] l, logic signed [COUNT_W-1:0] r);
      longint lft, rgt, avg, diff;
      logic signed [79:0] lat, turn;
      logic signed [COUNT_W-1:0] t_dist, t_turn;
      drive_word_t w;
      lft = l;
      rgt = r;
      avg = (lft + rgt) / 2;
      diff = lft - rgt;
      t_dist = regs[ddpid_pkg::REG_TARGET_DISTANCE];
      t_turn = regs[ddpid_pkg::REG_TARGET_TURN];
      lat = loop_step(LAT_LOOP, t_dist, avg, ddpid_pkg::REG_LAT_GAIN_P);
      turn = loop_step(TURN_LOOP, t_turn, diff, ddpid_pkg::REG_TURN_GAIN_P);
      w.left = clamp_drive(lat + turn);
      w.right = clamp_drive(lat - turn);
      expected_drives.push_back(w);
    endfunction

    function void compare_drives(logic signed [DRV_W-1:0] l,
                                 logic signed [DRV_W-1:0] r);
      drive_word_t want;
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected drive word: left %0d right %0d", l, r);
      end else begin
        want = expected_drives.pop_front();
        if (want.left !== l || want.right !== r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("drive word differs: expected left %0d right %0d, got left %0d right %0d",
                     want.left, want.right, l, r);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [ddpid_pkg::CFG_IDX_BITS-1:0] wr_index;
  logic [REG_W-1:0] wr_data;
  bit src_idle;
  bit sink_idle;
  bit hold_req;
  drive_scoreboard sb;

  ddpid_in_if counts_if ();
  ddpid_out_if drives_if ();

  differential_drive_dual_pid_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .counts   (counts_if),
    .drives   (drives_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [REG_W-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 24'($urandom());
      default: return 24'($urandom_range(0, (1 << $urandom_range(4, 18)) - 1));
    endcase
  endfunction

  function automatic logic [REG_W-1:0] rand_target();
    case ($urandom_range(0, 9))
      0: return COUNT_MAX;
      1: return COUNT_MIN;
      2, 3: return 24'($urandom());
      default: return 24'(longint'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic logic signed [COUNT_W-1:0] extreme_count();
    case ($urandom_range(0, 4))
      0: return COUNT_MAX;
      1: return COUNT_MIN;
      2: return 24'sd0;
      3: return -24'sd1;
      default: return 24'sd1;
    endcase
  endfunction

  task automatic send_counts(input logic signed [COUNT_W-1:0] l,
                             input logic signed [COUNT_W-1:0] r);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      counts_if.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    counts_if.valid <= 1'b1;
    counts_if.left_count <= l;
    counts_if.right_count <= r;
    @(posedge clk);
    while (!counts_if.ready) @(posedge clk);
    sb.predict_drives(l, r);
  endtask

  task automatic send_random_counts();
    int unsigned sel;
    longint span, half_turn, lft, rgt;
    logic signed [COUNT_W-1:0] t_dist, t_turn;
    sel = $urandom_range(0, 99);
    t_dist = sb.regs[ddpid_pkg::REG_TARGET_DISTANCE];
    t_turn = sb.regs[ddpid_pkg::REG_TARGET_TURN];
    if (sel < 70) begin
      span = longint'(1) << $urandom_range(0, 12);
      half_turn = longint'(t_turn) / 2;
      lft = longint'(t_dist) + half_turn + longint'($urandom_range(0, 2 * span)) - span;
      rgt = longint'(t_dist) - half_turn + longint'($urandom_range(0, 2 * span)) - span;
      send_counts(24'(lft), 24'(rgt));
    end else if (sel < 85) begin
      send_counts(24'($urandom()), 24'($urandom()));
    end else begin
      send_counts(extreme_count(), extreme_count());
    end
  endtask

  task automatic wait_idle();
    counts_if.valid <= 1'b0;
    while (sb.expected_drives.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input ddpid_pkg::cfg_reg_t idx, input logic [REG_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input logic [REG_W-1:0] target_d, target_t,
                           input logic [REG_W-1:0] lat_p, lat_i, lat_d,
                           input logic [REG_W-1:0] turn_p, turn_i, turn_d);
    wait_idle();
    write_reg(ddpid_pkg::REG_TARGET_DISTANCE, target_d);
    write_reg(ddpid_pkg::REG_TARGET_TURN, target_t);
    write_reg(ddpid_pkg::REG_LAT_GAIN_P, lat_p);
    write_reg(ddpid_pkg::REG_LAT_GAIN_I, lat_i);
    write_reg(ddpid_pkg::REG_LAT_GAIN_D, lat_d);
    write_reg(ddpid_pkg::REG_TURN_GAIN_P, turn_p);
    write_reg(ddpid_pkg::REG_TURN_GAIN_I, turn_i);
    write_reg(ddpid_pkg::REG_TURN_GAIN_D, turn_d);
    wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && drives_if.valid && drives_if.ready)
      sb.compare_drives(drives_if.left_drive, drives_if.right_drive);
  end

  initial begin
    drives_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        drives_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_idle && $urandom_range(0, 3) == 0) begin
        drives_if.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        drives_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #(8_000_000);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    sb = new();
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= ddpid_pkg::REG_TARGET_DISTANCE;
    wr_data <= '0;
    counts_if.valid <= 1'b0;
    counts_if.left_count <= '0;
    counts_if.right_count <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: extremes, averages that round toward zero, zero error.
    send_counts(24'sd0, 24'sd0);
    send_counts(COUNT_MAX, COUNT_MAX);
    send_counts(COUNT_MIN, COUNT_MIN);
    send_counts(COUNT_MAX, COUNT_MIN);
    send_counts(COUNT_MIN, COUNT_MAX);
    send_counts(-24'sd1, 24'sd0);
    send_counts(-24'sd3, 24'sd0);
    send_counts(24'sd675, 24'sd325);
    send_counts(24'sd675, 24'sd325);

    configure(COUNT_MAX, COUNT_MIN, '1, '1, '1, '1, '1, '1);
    send_counts(COUNT_MIN, COUNT_MIN);
    send_counts(COUNT_MAX, COUNT_MAX);
    send_counts(24'sd0, 24'sd0);
    send_counts(COUNT_MAX, COUNT_MIN);

    // Huge lateral and turn terms that cancel on one side only.
    configure('0, '0, GAIN_ONE, '0, '0, GAIN_ONE, '0, '0);
    send_counts(24'sd3000003, 24'sd1000000);
    send_counts(-24'sd3000003, -24'sd1000000);
    send_counts(24'sd1000000, 24'sd3000000);

    for (int ph = 0; ph < 5; ph++) begin
      configure(rand_target(), rand_target(), rand_gain(), rand_gain(), rand_gain(),
                rand_gain(), rand_gain(), rand_gain());
      src_idle = (ph == 1 || ph > 2);
      sink_idle = (ph != 0);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) send_random_counts();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.expected_drives.size() != 0) begin
      sb.mismatches++;
      $display("%0d drive words never arrived", sb.expected_drives.size());
    end
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ differential_drive_dual_pid_unit.f @@
+incdir+rtl
rtl/ddpid_pkg.sv
rtl/ddpid_if.sv
rtl/ddpid_loop.sv
rtl/differential_drive_dual_pid_unit.sv
rtl/ddpid_checker.sv
tb/tb_differential_drive_dual_pid_unit.sv
